>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the call counter table RTL.
// Needs no other file; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KCCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KCCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define KCCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hw/rtl/kcct_pkg.sv
// Shared constants, types and helper functions of the call counter table.
// Used by the controller, the datapath and the top level; depends on nothing.
package kcct_pkg;

    localparam int TABLE_DEPTH    = 256;
    localparam int COUNT_BITS     = 16;
    localparam int INDEX_BITS     = $clog2(TABLE_DEPTH);
    localparam int FILL_BITS      = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS       = 30;
    localparam int DIR_BITS       = 2;
    localparam int OUT_INDEX_BITS = 8;
    localparam int OUT_COUNT_BITS = 16;
    localparam int OUT_USED_BITS  = 9;
    localparam int S_TDATA_BITS   = 32;
    localparam int M_TDATA_BITS   = 96;
    localparam int M_TUSER_BITS   = 2;

    localparam logic [DIR_BITS-1:0] DIR_UNKNOWN  = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_OUTGOING = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_INCOMING = 2'd2;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        count_t total;
        count_t incoming;
        count_t outgoing;
    } counts_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic fetch;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_stall;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_COMMIT
    } state_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

endpackage

>>> hw/rtl/kcct_ctrl.sv
// Sequencer of the call counter table: accept, key scan, count fetch, commit.
// Depends on kcct_pkg and assert_macros.svh; drives the datapath by commands.
`include "assert_macros.svh"
module kcct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  kcct_pkg::status_t status,
    output kcct_pkg::cmd_t    cmd
);
    import kcct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.hit) begin
                    state_next = ST_FETCH;
                end else if (status.miss) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!status.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `KCCT_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0({cmd.capture, cmd.scan, cmd.fetch, cmd.commit}), "more than one datapath command at once")
    `KCCT_ASSERT_NEXT(a_capture_scan, aclk, aresetn, cmd.capture, state_reg == ST_SCAN, "capture not followed by the key scan")
    `KCCT_ASSERT(a_fetch_after_hit, aclk, aresetn, (state_reg == ST_FETCH) |-> $past(status.hit), "count fetch without a key hit")

endmodule

>>> hw/rtl/kcct_datapath.sv
// Datapath of the call counter table: key and count memories, scan compare,
// saturating update, running top tracker and the result register. Depends on kcct_pkg.
`include "assert_macros.svh"
module kcct_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  kcct_pkg::cmd_t                       cmd,
    output kcct_pkg::status_t                    status,
    input  logic [kcct_pkg::KEY_BITS-1:0]        in_key,
    input  logic [kcct_pkg::DIR_BITS-1:0]        in_dir,
    input  logic                                 in_last,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [kcct_pkg::M_TDATA_BITS-1:0]    m_tdata,
    output logic [kcct_pkg::M_TUSER_BITS-1:0]    m_tuser,
    output logic                                 m_tlast
);
    import kcct_pkg::*;

    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    counts_t               cnt_mem [TABLE_DEPTH];

    logic [KEY_BITS-1:0]   key_reg;
    logic [DIR_BITS-1:0]   dir_reg;
    logic                  last_reg;
    logic [FILL_BITS-1:0]  scan_idx_reg;
    logic                  cmp_vld_reg;
    logic [INDEX_BITS-1:0] cmp_idx_reg;
    logic [KEY_BITS-1:0]   key_rd_reg;
    counts_t               cnt_rd_reg;
    logic [INDEX_BITS-1:0] slot_reg;
    logic                  new_reg;
    logic                  full_reg;
    logic [FILL_BITS-1:0]  entry_count_reg;
    logic [FILL_BITS-1:0]  entry_count_next;
    logic [INDEX_BITS-1:0] top_slot_reg;
    logic [INDEX_BITS-1:0] top_slot_next;
    count_t                top_count_reg;
    count_t                top_count_next;
    logic                  m_valid_reg;
    logic [M_TDATA_BITS-1:0] m_data_reg;
    logic [M_TUSER_BITS-1:0] m_user_reg;
    logic                  m_last_reg;

    logic                  scan_more;
    logic                  hit;
    logic                  miss;
    logic                  store;
    counts_t               cnt_old;
    counts_t               cnt_new;
    logic                  top_take;
    logic [M_TDATA_BITS-1:0] data_next;

    assign scan_more = scan_idx_reg < entry_count_reg;
    assign hit       = cmd.scan && cmp_vld_reg && (key_rd_reg == key_reg);
    assign miss      = cmd.scan && !hit && !scan_more;
    assign store     = cmd.commit && !full_reg;

    assign status.hit       = hit;
    assign status.miss      = miss;
    assign status.out_stall = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            key_rd_reg <= key_mem[scan_idx_reg[INDEX_BITS-1:0]];
        end
        if (store && new_reg) begin
            key_mem[slot_reg] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            cnt_rd_reg <= cnt_mem[slot_reg];
        end
        if (store) begin
            cnt_mem[slot_reg] <= cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg  <= in_key;
            dir_reg  <= in_dir;
            last_reg <= in_last;
        end
        if (hit) begin
            slot_reg <= cmp_idx_reg;
            new_reg  <= 1'b0;
            full_reg <= 1'b0;
        end else if (miss) begin
            slot_reg <= entry_count_reg[INDEX_BITS-1:0];
            new_reg  <= 1'b1;
            full_reg <= (entry_count_reg == FILL_BITS'(TABLE_DEPTH));
        end
        if (cmd.scan) begin
            cmp_idx_reg <= scan_idx_reg[INDEX_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end else if (cmd.capture) begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end else if (cmd.scan) begin
            cmp_vld_reg <= scan_more;
            if (scan_more) begin
                scan_idx_reg <= scan_idx_reg + FILL_BITS'(1);
            end
        end
    end

    always_comb begin
        cnt_old          = new_reg ? '0 : cnt_rd_reg;
        cnt_new.total    = sat_inc(cnt_old.total);
        cnt_new.incoming = (dir_reg == DIR_INCOMING) ? sat_inc(cnt_old.incoming)
                                                     : cnt_old.incoming;
        cnt_new.outgoing = (dir_reg == DIR_OUTGOING) ? sat_inc(cnt_old.outgoing)
                                                     : cnt_old.outgoing;
        top_take = !full_reg && ((cnt_new.incoming > top_count_reg) ||
                   ((cnt_new.incoming == top_count_reg) && (slot_reg < top_slot_reg)));
        top_slot_next    = top_take ? slot_reg : top_slot_reg;
        top_count_next   = top_take ? cnt_new.incoming : top_count_reg;
        entry_count_next = (new_reg && !full_reg) ? entry_count_reg + FILL_BITS'(1)
                                                  : entry_count_reg;
        data_next        = '0;
        data_next[88:80] = OUT_USED_BITS'(entry_count_next);
        data_next[79:64] = OUT_COUNT_BITS'(top_count_next);
        data_next[63:56] = OUT_INDEX_BITS'(top_slot_next);
        if (!full_reg) begin
            data_next[55:40] = OUT_COUNT_BITS'(cnt_new.outgoing);
            data_next[39:24] = OUT_COUNT_BITS'(cnt_new.incoming);
            data_next[23:8]  = OUT_COUNT_BITS'(cnt_new.total);
            data_next[7:0]   = OUT_INDEX_BITS'(slot_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            top_slot_reg    <= '0;
            top_count_reg   <= '0;
        end else if (cmd.commit) begin
            entry_count_reg <= entry_count_next;
            top_slot_reg    <= top_slot_next;
            top_count_reg   <= top_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= data_next;
            m_user_reg <= {full_reg, new_reg && !full_reg};
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `KCCT_ASSERT(a_fill_bound, aclk, aresetn, entry_count_reg <= FILL_BITS'(TABLE_DEPTH), "entry count beyond table depth")
    `KCCT_ASSERT(a_hit_in_range, aclk, aresetn, hit |-> (FILL_BITS'(cmp_idx_reg) < entry_count_reg), "key hit on an unused slot")
    `KCCT_ASSERT(a_no_overwrite, aclk, aresetn, cmd.commit |-> !(m_valid_reg && !m_tready), "result register overwritten while stalled")
    `KCCT_ASSERT(a_top_in_range, aclk, aresetn, (entry_count_reg == '0) || (FILL_BITS'(top_slot_reg) < entry_count_reg), "top slot outside the used entries")
    `KCCT_ASSERT_NEXT(a_commit_valid, aclk, aresetn, cmd.commit, m_valid_reg, "commit did not present a result")

endmodule

>>> hw/rtl/keyed_call_counter_table.sv
// Top level of the call counter table: streaming ports, controller and datapath.
// Depends on kcct_pkg, kcct_ctrl and kcct_datapath.
//
//  Channel  Direction  Transfer carries
//  s_       in         phone number (tdata), direction (tuser), last record (tlast)
//  m_       out        slot, counts, top slot, fill (tdata), new/full flags (tuser), batch end
//
// Each record scans the keys of the N entries in use, one key memory read per stored entry,
// then a hit reads that slot's counts, and a write-back commit follows.
// A hit ends the scan early, after the matching slot's compare; a miss skips the count read.
// Reset empties the table at once through the fill count; no clearing pass runs.
// A stalled result holds the next record in its commit step; no record is taken meanwhile.
module keyed_call_counter_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: phone_number[29:0], zero pad[31:30]
    input  logic [kcct_pkg::S_TDATA_BITS-1:0] s_tdata,
    // s_tuser: direction[1:0]
    input  logic [kcct_pkg::DIR_BITS-1:0]     s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: entry_index[7:0], total_calls[23:8], incoming_calls[39:24],
    // outgoing_calls[55:40], top_index[63:56], top_incoming[79:64],
    // entries_used[88:80], zero pad[95:89]
    output logic [kcct_pkg::M_TDATA_BITS-1:0] m_tdata,
    // m_tuser: was_new[0], table_full[1]
    output logic [kcct_pkg::M_TUSER_BITS-1:0] m_tuser,
    output logic                              m_tlast
);
    import kcct_pkg::*;

    cmd_t    cmd;
    status_t status;

    kcct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kcct_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_key   (s_tdata[KEY_BITS-1:0]),
        .in_dir   (s_tuser),
        .in_last  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
